>>> rtl/core/bdph_pkg.sv
// Package: shared constants and types for the button debounce press/hold core.
`default_nettype none
package bdph_pkg;

    localparam int BUTTON_COUNT  = 4;
    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 8;
    localparam int CFG_W         = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd2000;

    typedef enum logic {
        CFG_DEBOUNCE = 1'b0,
        CFG_HOLD     = 1'b1
    } t_cfg_addr;

endpackage
`default_nettype wire

>>> rtl/core/button_debounce_press_hold_core.sv
// Top level: four-button debouncer with short-press and hold event detection.
//
// Usage:
//   Slave stream (i_s_axis_*): one transaction per poll, carrying a ms
//   timestamp and the raw pressed level of each button.
//   Master stream (o_m_axis_*): exactly one transaction per poll, carrying the
//   press and hold event bits of that poll, in poll order.
//   Config port: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
//   (0 debounce time, 1 hold time) at the clock edge; write only when idle.
//   Path: an accepted poll is held in the input register, and its result in the
//   result register, which drives o_m_axis_tvalid. Throughput: one poll per cycle
//   unless the output stalls, set by the single state update pass between the two.
//   Stall: while the result register is held by a low i_m_axis_tready, the
//   input register still takes one more poll, then o_s_axis_tready drops.
//   Reset (synchronous, i_rst_n low): clears all per-button state, empties
//   both registers and restores debounce 30 ms and hold 2000 ms.
`default_nettype none
module button_debounce_press_hold_core #(
    parameter int TIME_BITS = bdph_pkg::TIME_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [31:0] now_ms, [35:32] raw_pressed, [39:36] zero
    input  wire logic [bdph_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [3:0] press_events, [7:4] hold_events
    output logic [bdph_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_addr,
    input  wire logic [bdph_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import bdph_pkg::*;

    localparam int B = BUTTON_COUNT;

    logic [CFG_W-1:0]     r_debounce_ms;
    logic [CFG_W-1:0]     r_hold_ms;

    logic                 r_in_valid;
    logic [TIME_BITS-1:0] r_in_now;
    logic [B-1:0]         r_in_raw;

    logic                 r_out_valid;
    logic [B-1:0]         r_out_press;
    logic [B-1:0]         r_out_hold;

    logic [B-1:0]         r_last_raw;
    logic [TIME_BITS-1:0] r_chg_time [B];
    logic [B-1:0]         r_down;
    logic [TIME_BITS-1:0] r_start_time [B];
    logic [B-1:0]         r_fired;

    logic [B-1:0]         n_last_raw;
    logic [TIME_BITS-1:0] n_chg_time [B];
    logic [B-1:0]         n_down;
    logic [TIME_BITS-1:0] n_start_time [B];
    logic [B-1:0]         n_fired;
    logic [B-1:0]         n_press;
    logic [B-1:0]         n_hold;

    logic                 adv;
    logic                 in_fire;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_hold, r_out_press};

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RESET;
            r_hold_ms     <= HOLD_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_addr'(i_cfg_addr))
                    CFG_DEBOUNCE: r_debounce_ms <= i_cfg_wdata;
                    CFG_HOLD:     r_hold_ms     <= i_cfg_wdata;
                    default:      r_hold_ms     <= r_hold_ms;
                endcase
            end
        end
    end

    // Per-button update
    always_comb begin
        logic [TIME_BITS-1:0] el_chg;
        logic [TIME_BITS-1:0] el_start;
        logic                 raw;
        n_last_raw = r_last_raw;
        n_down     = r_down;
        n_fired    = r_fired;
        n_press    = '0;
        n_hold     = '0;
        for (int i = 0; i < B; i++) begin
            n_chg_time[i]   = r_chg_time[i];
            n_start_time[i] = r_start_time[i];
            raw      = r_in_raw[i];
            el_chg   = r_in_now - r_chg_time[i];
            el_start = r_in_now - r_start_time[i];
            if (raw != r_last_raw[i]) begin
                n_last_raw[i] = raw;
                n_chg_time[i] = r_in_now;
            end else if (el_chg >= TIME_BITS'(r_debounce_ms)) begin
                if (raw && !r_down[i]) begin
                    n_down[i]       = 1'b1;
                    n_start_time[i] = r_in_now;
                    n_fired[i]      = 1'b0;
                end else if (raw && r_down[i]) begin
                    if (!r_fired[i] && el_start >= TIME_BITS'(r_hold_ms)) begin
                        n_fired[i] = 1'b1;
                        n_hold[i]  = 1'b1;
                    end
                end else if (!raw && r_down[i]) begin
                    n_down[i]  = 1'b0;
                    n_press[i] = !r_fired[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_raw  <= '0;
            r_down      <= '0;
            r_fired     <= '0;
            for (int i = 0; i < B; i++) begin
                r_chg_time[i]   <= '0;
                r_start_time[i] <= '0;
            end
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_last_raw  <= n_last_raw;
                r_down      <= n_down;
                r_fired     <= n_fired;
                for (int i = 0; i < B; i++) begin
                    r_chg_time[i]   <= n_chg_time[i];
                    r_start_time[i] <= n_start_time[i];
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_now <= i_s_axis_tdata[TIME_BITS-1:0];
            r_in_raw <= i_s_axis_tdata[NOW_W +: B];
        end
        if (adv) begin
            r_out_press <= n_press;
            r_out_hold  <= n_hold;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/bdph_checker.sv
// Checker: port-level assertions for the button debounce core, with its bind.
`default_nettype none
module bdph_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_s_axis_tready,
    input wire logic                              o_m_axis_tvalid,
    input wire logic                              i_m_axis_tready,
    input wire logic [bdph_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import bdph_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result transaction changed while stalled");

    a_press_hold_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata[BUTTON_COUNT-1:0] &
              o_m_axis_tdata[2*BUTTON_COUNT-1:BUTTON_COUNT]) == '0))
        else $error("press and hold event on the same button");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind button_debounce_press_hold_core bdph_checker u_bdph_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the four-button debounce core with press and hold events.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdph_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [31:0] now_ms, [35:32] raw_pressed, [39:36] zero
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [3:0] press_events, [7:4] hold_events
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic                   i_cfg_addr = CFG_DEBOUNCE;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;

    button_debounce_press_hold_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // debouncer state mirror
    logic [CFG_W-1:0]        debounce_ms;
    logic [CFG_W-1:0]        hold_ms;
    logic [BUTTON_COUNT-1:0] seen_level;
    logic [BUTTON_COUNT-1:0] is_down;
    logic [BUTTON_COUNT-1:0] hold_done;
    logic [NOW_W-1:0]        change_at [BUTTON_COUNT];
    logic [NOW_W-1:0]        down_at [BUTTON_COUNT];

    logic [OUT_TDATA_W-1:0]  expected_events [$];
    int unsigned             burst_left;
    int unsigned             long_stall_cycles;
    int unsigned             error_count;
    int unsigned             polls_sent;
    int unsigned             results_checked;
    int unsigned             press_seen;
    int unsigned             hold_seen;
    int unsigned             settings_used;

    // stimulus generator state for well-formed button activity
    logic [NOW_W-1:0]        poll_time;
    logic [BUTTON_COUNT-1:0] target_level;
    int unsigned             toggle_in [BUTTON_COUNT];
    int unsigned             bounce_left [BUTTON_COUNT];

    function automatic logic [OUT_TDATA_W-1:0] debounce_poll(
        input logic [NOW_W-1:0] now,
        input logic [BUTTON_COUNT-1:0] raw
    );
        logic [BUTTON_COUNT-1:0] press;
        logic [BUTTON_COUNT-1:0] hold;
        logic [NOW_W-1:0]        since;
        press = '0;
        hold  = '0;
        for (int b = 0; b < BUTTON_COUNT; b++) begin
            if (raw[b] != seen_level[b]) begin
                seen_level[b] = raw[b];
                change_at[b]  = now;
            end else begin
                since = now - change_at[b];
                if (since >= {16'd0, debounce_ms}) begin
                    if (raw[b] && !is_down[b]) begin
                        is_down[b]   = 1'b1;
                        down_at[b]   = now;
                        hold_done[b] = 1'b0;
                    end else if (raw[b] && is_down[b]) begin
                        since = now - down_at[b];
                        if (!hold_done[b] && since >= {16'd0, hold_ms}) begin
                            hold_done[b] = 1'b1;
                            hold[b]      = 1'b1;
                        end
                    end else if (!raw[b] && is_down[b]) begin
                        is_down[b] = 1'b0;
                        if (!hold_done[b])
                            press[b] = 1'b1;
                    end
                end
            end
        end
        return {hold, press};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 30)
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        logic [OUT_TDATA_W-1:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("unexpected transaction", o_m_axis_tdata, 0);
            end else begin
                want = expected_events.pop_front();
                results_checked++;
                if (want[3:0] != 0) press_seen++;
                if (want[7:4] != 0) hold_seen++;
                if (o_m_axis_tdata[3:0] != want[3:0])
                    report_mismatch("press_events", o_m_axis_tdata[3:0], want[3:0]);
                if (o_m_axis_tdata[7:4] != want[7:4])
                    report_mismatch("hold_events", o_m_axis_tdata[7:4], want[7:4]);
            end
        end
    end

    initial begin : sink_pacing
        int unsigned mode;
        int unsigned span;
        int unsigned n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            for (int k = 0; k < span; k++) begin
                if (long_stall_cycles != 0) begin
                    n = long_stall_cycles;
                    long_stall_cycles = 0;
                    i_m_axis_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                case (mode)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       i_m_axis_tready <= (k % 3) != 2;
                    default: i_m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_poll(input logic [NOW_W-1:0] now, input logic [BUTTON_COUNT-1:0] raw);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, raw, now};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_events.push_back(debounce_poll(now, raw));
        polls_sent++;
    endtask

    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr idx, input logic [CFG_W-1:0] value);
        wait_for_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: debounce_ms = value;
            CFG_HOLD:     hold_ms     = value;
        endcase
        settings_used++;
    endtask

    task automatic test_directed_cases();
        // reset timing: debounce 30, hold 2000
        send_poll(32'd0, 4'h0);
        send_poll(32'hFFFF_FFFF, 4'h0);
        send_poll(32'd100, 4'hF);
        send_poll(32'd129, 4'hF);
        send_poll(32'd130, 4'hF);
        send_poll(32'd2129, 4'hF);
        send_poll(32'd2130, 4'hF);
        send_poll(32'd2200, 4'hF);
        send_poll(32'd2201, 4'h0);
        send_poll(32'd2231, 4'h0);
        send_poll(32'd2300, 4'h5);
        send_poll(32'd2330, 4'h5);
        send_poll(32'd2340, 4'h0);
        send_poll(32'd2370, 4'h0);
        // timestamp wrap, then a backwards step
        send_poll(32'hFFFF_FFF0, 4'hA);
        send_poll(32'h0000_000E, 4'hA);
        send_poll(32'h0000_0020, 4'h0);
        send_poll(32'h0000_003E, 4'h0);
        send_poll(32'h0000_0100, 4'h1);
        send_poll(32'h0000_0050, 4'h1);
        send_poll(32'h0000_0820, 4'h1);
        // zero debounce and zero hold
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_HOLD, 16'd0);
        send_poll(32'h0000_0900, 4'h2);
        send_poll(32'h0000_0900, 4'h2);
        send_poll(32'h0000_0900, 4'h2);
        send_poll(32'h0000_0901, 4'h0);
        send_poll(32'h0000_0901, 4'h0);
    endtask

    task automatic test_random_polls(
        input logic [CFG_W-1:0] debounce,
        input logic [CFG_W-1:0] hold,
        input int unsigned      count,
        input int unsigned      max_step
    );
        logic [BUTTON_COUNT-1:0] raw;
        write_reg(CFG_DEBOUNCE, debounce);
        write_reg(CFG_HOLD, hold);
        poll_time = $urandom();
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 49))
                0:       poll_time = $urandom();
                1:       poll_time = poll_time - $urandom_range(0, 3 * max_step);
                default: poll_time = poll_time + $urandom_range(0, max_step);
            endcase
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                if (toggle_in[b] == 0) begin
                    target_level[b] = ~target_level[b];
                    toggle_in[b]    = target_level[b] ? $urandom_range(1, 60)
                                                      : $urandom_range(1, 30);
                    bounce_left[b]  = $urandom_range(0, 4);
                end else begin
                    toggle_in[b]--;
                end
                if (bounce_left[b] != 0) begin
                    raw[b] = 1'($urandom_range(0, 1));
                    bounce_left[b]--;
                end else begin
                    raw[b] = target_level[b];
                end
            end
            if ($urandom_range(0, 14) == 0)
                raw = 4'($urandom_range(0, 15));
            send_poll(poll_time, raw);
        end
    endtask

    task automatic test_output_stall();
        i_s_axis_tvalid <= 1'b0;
        long_stall_cycles = 60;
        while (long_stall_cycles != 0) @(posedge i_clk);
        burst_left = 40;
        for (int n = 0; n < 30; n++) begin
            poll_time = poll_time + $urandom_range(0, 40);
            send_poll(poll_time, 4'($urandom_range(0, 15)));
        end
        // pause until the pipeline is empty, then resume
        wait_for_results();
        for (int n = 0; n < 10; n++) begin
            poll_time = poll_time + $urandom_range(0, 40);
            send_poll(poll_time, 4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        debounce_ms  = DEBOUNCE_RESET;
        hold_ms      = HOLD_RESET;
        seen_level   = '0;
        is_down      = '0;
        hold_done    = '0;
        target_level = '0;
        for (int b = 0; b < BUTTON_COUNT; b++) begin
            change_at[b]   = '0;
            down_at[b]     = '0;
            toggle_in[b]   = $urandom_range(0, 20);
            bounce_left[b] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_polls(16'd30, 16'd2000, 110, 150);
        test_random_polls(16'd0, 16'd0, 130, 5);
        test_output_stall();
        test_random_polls(16'd5, 16'd40, 110, 6);
        test_random_polls(16'd65535, 16'd65535, 110, 8000);
        test_random_polls(16'd0, 16'd65535, 110, 4000);
        test_random_polls(16'd65535, 16'd0, 110, 8000);
        test_random_polls(16'd12, 16'd150, 110, 10);

        wait_for_results();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d results of %0d polls over %0d register writes",
                 results_checked, polls_sent, settings_used);
        $display("Debounce and hold timing exercised with %0d press and %0d hold events",
                 press_seen, hold_seen);
        if (error_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
